FILE: src/crcfr_pkg.sv
`timescale 1ns / 1ps
package crcfr_pkg;

  // Frame format limits and CRC-16/CCITT-FALSE constants
  localparam int MAX_PAYLOAD_DEF = 256;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Sync byte values after reset
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_idx_t;

  // Item commands
  typedef enum logic [1:0] {
    CMD_LINK = 2'd0,
    CMD_READ = 2'd1,
    CMD_TAKE = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // Frame event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_CRC_ERR  = 3'd2,
    EV_DROPPED  = 3'd3,
    EV_BAD_LEN  = 3'd4
  } frame_ev_t;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  data;       // link byte or read index
    logic [15:0] cap;        // host capacity for take
    logic        sync1_hit;  // link byte equals first sync byte
    logic        sync2_hit;  // link byte equals second sync byte
  } op_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: src/crcfr_front.sv
`timescale 1ns / 1ps
module crcfr_front
  import crcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_link_byte,
  input  logic [7:0]  in_read_index,
  input  logic [15:0] in_dest_capacity,
  output logic        push_valid,
  input  logic        push_ready,
  output op_t         push_op
);

  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;

  // Hold the sync byte registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Classify the item: pick its operand, compare against sync bytes
  always_comb begin
    push_op.cmd       = cmd_t'(in_cmd);
    push_op.data      = (cmd_t'(in_cmd) == CMD_READ) ? in_read_index : in_link_byte;
    push_op.cap       = in_dest_capacity;
    push_op.sync1_hit = (in_link_byte == sync_first_r);
    push_op.sync2_hit = (in_link_byte == sync_second_r);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

FILE: src/crcfr_queue.sv
`timescale 1ns / 1ps
module crcfr_queue
  import crcfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  op_t             q_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: src/crcfr_back.sv
`timescale 1ns / 1ps
module crcfr_back
  import crcfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  op_t        pop_op,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_frame_event,
  output logic       out_ready_flag,
  output logic [8:0] out_held_length,
  output logic [7:0] out_read_byte,
  output logic [8:0] out_taken_length
);

  localparam int AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW     = AW + 1;
  localparam int LW     = $clog2(MAX_PAYLOAD + 1);
  localparam int MDEPTH = 2 ** (AW + 1);

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_LO  = 3'd4,
    PH_CRC_HI  = 3'd5
  } phase_t;

  // Parser and mailbox state
  phase_t      phase_r,   phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [AW-1:0] pay_cnt_r, pay_cnt_nxt;
  logic [15:0] exp_len_r, exp_len_nxt;
  logic [15:0] crc_r,     crc_nxt;
  logic [7:0]  crc_lo_r,  crc_lo_nxt;
  logic [LW-1:0] held_len_r, held_len_nxt;
  logic        full_r,    full_nxt;
  logic        bank_r,    bank_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  frame_ev_t   out_ev_r,    out_ev_nxt;
  logic        out_flag_r,  out_flag_nxt;
  logic [8:0]  out_hlen_r,  out_hlen_nxt;
  logic [8:0]  out_taken_r, out_taken_nxt;
  logic        rd_ok_r,     rd_ok_nxt;

  // Two-bank payload memory; the held frame lives in the bank not being filled
  logic [7:0]  mem [MDEPTH];
  logic [7:0]  mem_q_r;
  logic        mem_we;
  logic        mem_re;
  logic [AW:0] mem_waddr;
  logic [AW:0] mem_raddr;

  logic        fire;
  logic [15:0] crc_step;
  logic [15:0] len_full;
  logic [CW-1:0] pay_cnt_inc;
  logic [AW+7:0] idx_ext;
  logic [15:0] held16;
  logic [15:0] held16_nxt;
  logic [15:0] taken16;

  assign pop_ready   = !out_valid_r || out_ready;
  assign fire        = pop_valid && pop_ready;
  assign crc_step    = crc16_byte(crc_r, pop_op.data);
  assign len_full    = {pop_op.data, exp_len_r[7:0]};
  assign pay_cnt_inc = CW'({1'b0, pay_cnt_r}) + CW'(1);
  assign idx_ext     = {{AW{1'b0}}, pop_op.data};
  assign held16      = 16'(held_len_r);
  assign mem_waddr   = {bank_r, pay_cnt_r};
  assign mem_raddr   = {~bank_r, idx_ext[AW-1:0]};
  assign mem_re      = fire && (pop_op.cmd == CMD_READ);

  // Step the parser and mailbox for one item
  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    pay_cnt_nxt  = pay_cnt_r;
    exp_len_nxt  = exp_len_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    held_len_nxt = held_len_r;
    full_nxt     = full_r;
    bank_nxt     = bank_r;
    out_ev_nxt   = EV_NONE;
    rd_ok_nxt    = 1'b0;
    taken16      = '0;
    mem_we       = 1'b0;

    if (fire) begin
      case (pop_op.cmd)
        CMD_LINK: begin
          case (phase_r)
            PH_SYNC2: begin
              if (pop_op.sync2_hit) begin
                phase_nxt   = PH_HEADER;
                hdr_cnt_nxt = '0;
                crc_nxt     = CRC_INIT;
              end else begin
                phase_nxt = PH_SYNC1;
              end
            end
            PH_HEADER: begin
              crc_nxt = crc_step;
              if (hdr_cnt_r == 2'd1) begin
                exp_len_nxt = {8'h00, pop_op.data};
              end
              if (hdr_cnt_r == 2'd2) begin
                exp_len_nxt = len_full;
                hdr_cnt_nxt = '0;
                if (len_full > 16'(MAX_PAYLOAD)) begin
                  out_ev_nxt = EV_BAD_LEN;
                  phase_nxt  = PH_SYNC1;
                end else if (len_full == '0) begin
                  phase_nxt = PH_CRC_LO;
                end else begin
                  phase_nxt   = PH_PAYLOAD;
                  pay_cnt_nxt = '0;
                end
              end else begin
                hdr_cnt_nxt = hdr_cnt_r + 2'd1;
              end
            end
            PH_PAYLOAD: begin
              crc_nxt     = crc_step;
              mem_we      = 1'b1;
              pay_cnt_nxt = pay_cnt_inc[AW-1:0];
              if (pay_cnt_inc >= exp_len_r[CW-1:0]) begin
                phase_nxt = PH_CRC_LO;
              end
            end
            PH_CRC_LO: begin
              crc_lo_nxt = pop_op.data;
              phase_nxt  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
              if ({pop_op.data, crc_lo_r} != crc_r) begin
                out_ev_nxt = EV_CRC_ERR;
              end else if (full_r) begin
                out_ev_nxt = EV_DROPPED;
              end else begin
                // swap banks: the frame just filled becomes the held one
                held_len_nxt = exp_len_r[LW-1:0];
                full_nxt     = 1'b1;
                bank_nxt     = ~bank_r;
                out_ev_nxt   = EV_ACCEPT;
              end
              phase_nxt = PH_SYNC1;
            end
            default: begin
              phase_nxt = pop_op.sync1_hit ? PH_SYNC2 : PH_SYNC1;
            end
          endcase
        end
        CMD_READ: begin
          rd_ok_nxt = full_r && (16'(pop_op.data) < held16);
        end
        CMD_TAKE: begin
          if (full_r) begin
            taken16  = (held16 < pop_op.cap) ? held16 : pop_op.cap;
            full_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end

    held16_nxt    = 16'(held_len_nxt);
    out_flag_nxt  = full_nxt;
    out_hlen_nxt  = full_nxt ? held16_nxt[8:0] : 9'd0;
    out_taken_nxt = taken16[8:0];

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC1;
      hdr_cnt_r   <= '0;
      pay_cnt_r   <= '0;
      exp_len_r   <= '0;
      crc_r       <= CRC_INIT;
      crc_lo_r    <= '0;
      held_len_r  <= '0;
      full_r      <= 1'b0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      exp_len_r   <= exp_len_nxt;
      crc_r       <= crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
      held_len_r  <= held_len_nxt;
      full_r      <= full_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (fire) begin
      out_ev_r    <= out_ev_nxt;
      out_flag_r  <= out_flag_nxt;
      out_hlen_r  <= out_hlen_nxt;
      out_taken_r <= out_taken_nxt;
      rd_ok_r     <= rd_ok_nxt;
    end
  end

  // Write payload bytes, read held bytes with registered data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= pop_op.data;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_event  = out_ev_r;
  assign out_ready_flag   = out_flag_r;
  assign out_held_length  = out_hlen_r;
  assign out_read_byte    = rd_ok_r ? mem_q_r : 8'h00;
  assign out_taken_length = out_taken_r;

endmodule

FILE: src/crc_checked_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Byte-serial frame receiver with a one-slot mailbox. Link bytes are parsed
// as two sync bytes, sequence, 16-bit little-endian length, payload and a
// little-endian CRC-16/CCITT-FALSE over sequence, length and payload; a good
// frame is kept if the mailbox is empty, and the host reads held bytes by
// index and takes the frame. Every item gives one result. The block takes one
// item per clock; stalls on the result side fill a two-entry queue before
// input ready drops. An item waits in the queue, then its result in the back
// end's output register. The rate is set by the back end, which does the
// byte-wide CRC update, parser step and mailbox update for each item. The
// two payload banks swap roles on accept, so keeping a frame costs no copy.
module crc_checked_frame_receiver_unit
  import crcfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_link_byte,
  input  logic [7:0]  in_read_index,
  input  logic [15:0] in_dest_capacity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_event,
  output logic        out_ready_flag,
  output logic [8:0]  out_held_length,
  output logic [7:0]  out_read_byte,
  output logic [8:0]  out_taken_length
);

  logic push_valid;
  logic push_ready;
  op_t  push_op;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_op;

  // Accept and classify items
  crcfr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_link_byte     (in_link_byte),
    .in_read_index    (in_read_index),
    .in_dest_capacity (in_dest_capacity),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_op          (push_op)
  );

  // Decouple front and back
  crcfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // Parse frames, run the mailbox, register results
  crcfr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_op           (pop_op),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_event  (out_frame_event),
    .out_ready_flag   (out_ready_flag),
    .out_held_length  (out_held_length),
    .out_read_byte    (out_read_byte),
    .out_taken_length (out_taken_length)
  );

endmodule
